/* rtl/ubli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ubli_pkg;

  localparam int DEF_MAX_COLS     = 16;
  localparam int DEF_MAX_ROWS     = 16;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS        = 16;

  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [2:0] CFG_X_LOW     = 3'd0;
  localparam logic [2:0] CFG_X_HIGH    = 3'd1;
  localparam logic [2:0] CFG_GRID_COLS = 3'd2;
  localparam logic [2:0] CFG_Y_LOW     = 3'd3;
  localparam logic [2:0] CFG_Y_HIGH    = 3'd4;
  localparam logic [2:0] CFG_GRID_ROWS = 3'd5;

  localparam logic signed [15:0] RST_X_LOW     = 16'sd0;
  localparam logic signed [15:0] RST_X_HIGH    = 16'sd32767;
  localparam logic [4:0]         RST_GRID_COLS = 5'd16;
  localparam logic signed [15:0] RST_Y_LOW     = 16'sd0;
  localparam logic signed [15:0] RST_Y_HIGH    = 16'sd32767;
  localparam logic [4:0]         RST_GRID_ROWS = 5'd16;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_LOOKUP,
    KIND_FLAT
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } ctl_t;

  // Number of grid intervals along one axis after saturating the point count.
  function automatic int sat_nm1(input logic [4:0] n, input int maxv);
    int r;
    if (n < 5'd2) begin
      r = 1;
    end else if (int'(n) > maxv) begin
      r = maxv - 1;
    end else begin
      r = int'(n) - 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/ubli_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ubli_front #(
  parameter int MAX_COLS     = ubli_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = ubli_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_WIDTH = ubli_pkg::DEF_SAMPLE_WIDTH,
  parameter int CW           = 4,
  parameter int AW           = 8,
  localparam int NUMW        = 16 + CW
) (
  input  logic                     start,
  input  logic                     busy,
  input  logic                     req_type,
  input  logic [3:0]               entry_row,
  input  logic [3:0]               entry_col,
  input  logic signed [15:0]       entry_value,
  input  logic signed [15:0]       x_pos,
  input  logic signed [15:0]       y_pos,
  input  logic signed [15:0]       x_low,
  input  logic signed [15:0]       x_high,
  input  logic [4:0]               grid_cols,
  input  logic signed [15:0]       y_low,
  input  logic signed [15:0]       y_high,
  input  logic [4:0]               grid_rows,
  output logic                     push,
  output ubli_pkg::item_kind_t     kind,
  output logic [NUMW-1:0]          num_x,
  output logic [NUMW-1:0]          num_y,
  output logic [SAMPLE_WIDTH-1:0]  sample,
  output logic [AW-1:0]            waddr
);

  logic               flat;
  logic               in_range;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic [CW-1:0]      nm1_x;
  logic [CW-1:0]      nm1_y;

  always_comb begin
    flat = (x_high <= x_low) || (y_high <= y_low);
    in_range = (32'(entry_row) < MAX_ROWS) && (32'(entry_col) < MAX_COLS);

    if (x_pos < x_low) begin
      pos_x = x_low;
    end else if (x_pos > x_high) begin
      pos_x = x_high;
    end else begin
      pos_x = x_pos;
    end
    if (y_pos < y_low) begin
      pos_y = y_low;
    end else if (y_pos > y_high) begin
      pos_y = y_high;
    end else begin
      pos_y = y_pos;
    end

    diff_x = 17'(pos_x) - 17'(x_low);
    diff_y = 17'(pos_y) - 17'(y_low);
    nm1_x  = CW'(ubli_pkg::sat_nm1(grid_cols, MAX_COLS));
    nm1_y  = CW'(ubli_pkg::sat_nm1(grid_rows, MAX_ROWS));
    num_x  = NUMW'(diff_x[15:0]) * NUMW'(nm1_x);
    num_y  = NUMW'(diff_y[15:0]) * NUMW'(nm1_y);

    if (req_type == ubli_pkg::REQ_WRITE) begin
      kind = ubli_pkg::KIND_WRITE;
    end else if (flat) begin
      kind = ubli_pkg::KIND_FLAT;
    end else begin
      kind = ubli_pkg::KIND_LOOKUP;
    end

    // Writes outside the table are dropped here and never enter the queue.
    push   = start && !busy && ((req_type == ubli_pkg::REQ_LOOKUP) || in_range);
    sample = SAMPLE_WIDTH'(entry_value);
    waddr  = AW'(32'(entry_row) * MAX_COLS + 32'(entry_col));
  end

endmodule
`default_nettype wire

/* rtl/ubli_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ubli_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push_ok;
  logic         pop_ok;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/ubli_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module ubli_div #(
  parameter int CW    = 4,
  parameter int TAGW  = 1,
  localparam int NUMW  = 16 + CW,
  localparam int STEPS = CW + ubli_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  ubli_pkg::ctl_t     in_ctl,
  input  logic [NUMW-1:0]    num_x,
  input  logic [NUMW-1:0]    num_y,
  input  logic [15:0]        span_x,
  input  logic [15:0]        span_y,
  input  logic [TAGW-1:0]    in_tag,
  output ubli_pkg::ctl_t     out_ctl,
  output logic [STEPS-1:0]   quo_x,
  output logic [STEPS-1:0]   quo_y,
  output logic [TAGW-1:0]    out_tag
);

  // Restoring division of num * 2^16 by span, one quotient bit per stage.
  // The upper bits of the dividend are already below span, so only STEPS
  // quotient bits are produced.
  ubli_pkg::ctl_t    st_ctl [1:STEPS];
  logic [15:0]       rem_x  [1:STEPS];
  logic [15:0]       rem_y  [1:STEPS];
  logic [STEPS-1:0]  sh_x   [1:STEPS];
  logic [STEPS-1:0]  sh_y   [1:STEPS];
  logic [TAGW-1:0]   tag    [1:STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    ubli_pkg::ctl_t   cur_ctl;
    logic [15:0]      cur_rem_x;
    logic [15:0]      cur_rem_y;
    logic [STEPS-1:0] cur_sh_x;
    logic [STEPS-1:0] cur_sh_y;
    logic [TAGW-1:0]  cur_tag;
    logic [16:0]      trial_x;
    logic [16:0]      trial_y;
    logic             ge_x;
    logic             ge_y;

    if (s == 0) begin : g_first
      assign cur_ctl   = in_ctl;
      assign cur_rem_x = num_x[NUMW-1:CW];
      assign cur_rem_y = num_y[NUMW-1:CW];
      assign cur_sh_x  = {num_x[CW-1:0], 16'd0};
      assign cur_sh_y  = {num_y[CW-1:0], 16'd0};
      assign cur_tag   = in_tag;
    end else begin : g_next
      assign cur_ctl   = st_ctl[s];
      assign cur_rem_x = rem_x[s];
      assign cur_rem_y = rem_y[s];
      assign cur_sh_x  = sh_x[s];
      assign cur_sh_y  = sh_y[s];
      assign cur_tag   = tag[s];
    end

    always_comb begin
      trial_x = {cur_rem_x, cur_sh_x[STEPS-1]};
      trial_y = {cur_rem_y, cur_sh_y[STEPS-1]};
      ge_x    = trial_x >= {1'b0, span_x};
      ge_y    = trial_y >= {1'b0, span_y};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[s+1] <= '0;
      end else begin
        st_ctl[s+1] <= cur_ctl;
      end
      rem_x[s+1] <= ge_x ? 16'(trial_x - {1'b0, span_x}) : trial_x[15:0];
      rem_y[s+1] <= ge_y ? 16'(trial_y - {1'b0, span_y}) : trial_y[15:0];
      sh_x[s+1]  <= {cur_sh_x[STEPS-2:0], ge_x};
      sh_y[s+1]  <= {cur_sh_y[STEPS-2:0], ge_y};
      tag[s+1]   <= cur_tag;
    end
  end

  assign out_ctl = st_ctl[STEPS];
  assign quo_x   = sh_x[STEPS];
  assign quo_y   = sh_y[STEPS];
  assign out_tag = tag[STEPS];

endmodule
`default_nettype wire

/* rtl/ubli_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ubli_back #(
  parameter int MAX_COLS     = ubli_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = ubli_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_WIDTH = ubli_pkg::DEF_SAMPLE_WIDTH,
  parameter int CW           = 4,
  parameter int AW           = 8,
  localparam int STEPS       = CW + ubli_pkg::FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ubli_pkg::ctl_t           in_ctl,
  input  logic [STEPS-1:0]         quo_x,
  input  logic [STEPS-1:0]         quo_y,
  input  logic [SAMPLE_WIDTH-1:0]  in_sample,
  input  logic [AW-1:0]            in_waddr,
  input  logic [4:0]               grid_cols,
  input  logic [4:0]               grid_rows,
  output logic                     done,
  output logic signed [15:0]       z_value,
  output logic                     span_invalid
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int PW    = SW + 17;
  localparam int RW    = SW + 16;
  localparam int MW    = SW + 33;

  // Cell index and fraction.
  logic [CW-1:0]  nm1_x;
  logic [CW-1:0]  nm1_y;
  logic [CW-1:0]  q_x;
  logic [CW-1:0]  q_y;
  logic [CW-1:0]  ix;
  logic [CW-1:0]  iy;
  logic [16:0]    tx;
  logic [16:0]    ty;
  logic [AW-1:0]  base;

  always_comb begin
    nm1_x = CW'(ubli_pkg::sat_nm1(grid_cols, MAX_COLS));
    nm1_y = CW'(ubli_pkg::sat_nm1(grid_rows, MAX_ROWS));
    q_x   = quo_x[STEPS-1:ubli_pkg::FRAC_BITS];
    q_y   = quo_y[STEPS-1:ubli_pkg::FRAC_BITS];
    if (in_ctl.kind == ubli_pkg::KIND_FLAT) begin
      ix = '0;
      tx = '0;
    end else if (q_x >= nm1_x) begin
      ix = nm1_x - CW'(1);
      tx = ubli_pkg::FRAC_ONE;
    end else begin
      ix = q_x;
      tx = {1'b0, quo_x[ubli_pkg::FRAC_BITS-1:0]};
    end
    if (in_ctl.kind == ubli_pkg::KIND_FLAT) begin
      iy = '0;
      ty = '0;
    end else if (q_y >= nm1_y) begin
      iy = nm1_y - CW'(1);
      ty = ubli_pkg::FRAC_ONE;
    end else begin
      iy = q_y;
      ty = {1'b0, quo_y[ubli_pkg::FRAC_BITS-1:0]};
    end
    base = AW'(32'(iy) * MAX_COLS + 32'(ix));
  end

  ubli_pkg::ctl_t  i_ctl;
  logic [AW-1:0]   i_a00;
  logic [AW-1:0]   i_a01;
  logic [AW-1:0]   i_a10;
  logic [AW-1:0]   i_a11;
  logic [16:0]     i_tx;
  logic [16:0]     i_ty;
  logic [SW-1:0]   i_sample;
  logic [AW-1:0]   i_waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_ctl <= '0;
    end else begin
      i_ctl <= in_ctl;
    end
    i_a00    <= base;
    i_a01    <= AW'(32'(base) + 1);
    i_a10    <= AW'(32'(base) + MAX_COLS);
    i_a11    <= AW'(32'(base) + MAX_COLS + 1);
    i_tx     <= tx;
    i_ty     <= ty;
    i_sample <= in_sample;
    i_waddr  <= in_waddr;
  end

  // One table copy per corner; every write goes to all four copies in item order.
  logic [SW-1:0]   mem00 [DEPTH];
  logic [SW-1:0]   mem01 [DEPTH];
  logic [SW-1:0]   mem10 [DEPTH];
  logic [SW-1:0]   mem11 [DEPTH];
  logic [SW-1:0]   r_f00;
  logic [SW-1:0]   r_f01;
  logic [SW-1:0]   r_f10;
  logic [SW-1:0]   r_f11;
  ubli_pkg::ctl_t  r_ctl;
  logic [16:0]     r_tx;
  logic [16:0]     r_ty;

  always_ff @(posedge clk) begin
    if (i_ctl.valid && (i_ctl.kind == ubli_pkg::KIND_WRITE)) begin
      mem00[i_waddr] <= i_sample;
      mem01[i_waddr] <= i_sample;
      mem10[i_waddr] <= i_sample;
      mem11[i_waddr] <= i_sample;
    end
    r_f00 <= mem00[i_a00];
    r_f01 <= mem01[i_a01];
    r_f10 <= mem10[i_a10];
    r_f11 <= mem11[i_a11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ctl <= '0;
    end else begin
      r_ctl <= i_ctl;
    end
    r_tx <= i_tx;
    r_ty <= i_ty;
  end

  // Samples are offset to unsigned by flipping the sign bit.
  logic [SW-1:0]   b00;
  logic [SW-1:0]   b01;
  logic [SW-1:0]   b10;
  logic [SW-1:0]   b11;
  logic [16:0]     wx0;

  always_comb begin
    b00 = {~r_f00[SW-1], r_f00[SW-2:0]};
    b01 = {~r_f01[SW-1], r_f01[SW-2:0]};
    b10 = {~r_f10[SW-1], r_f10[SW-2:0]};
    b11 = {~r_f11[SW-1], r_f11[SW-2:0]};
    wx0 = ubli_pkg::FRAC_ONE - r_tx;
  end

  ubli_pkg::ctl_t  m1_ctl;
  logic [PW-1:0]   m1_p00;
  logic [PW-1:0]   m1_p01;
  logic [PW-1:0]   m1_p10;
  logic [PW-1:0]   m1_p11;
  logic [16:0]     m1_ty;
  logic [SW-1:0]   m1_f00;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_ctl <= '0;
    end else begin
      m1_ctl <= r_ctl;
    end
    m1_p00 <= PW'(b00) * PW'(wx0);
    m1_p01 <= PW'(b01) * PW'(r_tx);
    m1_p10 <= PW'(b10) * PW'(wx0);
    m1_p11 <= PW'(b11) * PW'(r_tx);
    m1_ty  <= r_ty;
    m1_f00 <= b00;
  end

  ubli_pkg::ctl_t  m2_ctl;
  logic [RW-1:0]   m2_ra;
  logic [RW-1:0]   m2_rb;
  logic [16:0]     m2_ty;
  logic [SW-1:0]   m2_f00;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_ctl <= '0;
    end else begin
      m2_ctl <= m1_ctl;
    end
    m2_ra  <= RW'(m1_p00 + m1_p01);
    m2_rb  <= RW'(m1_p10 + m1_p11);
    m2_ty  <= m1_ty;
    m2_f00 <= m1_f00;
  end

  ubli_pkg::ctl_t  m3_ctl;
  logic [MW-1:0]   m3_ma;
  logic [MW-1:0]   m3_mb;
  logic [SW-1:0]   m3_f00;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_ctl <= '0;
    end else begin
      m3_ctl <= m2_ctl;
    end
    m3_ma  <= MW'(m2_ra) * MW'(ubli_pkg::FRAC_ONE - m2_ty);
    m3_mb  <= MW'(m2_rb) * MW'(m2_ty);
    m3_f00 <= m2_f00;
  end

  logic [MW-1:0]         acc;
  logic [SW-1:0]         hi_sel;
  logic signed [SW-1:0]  z_full;

  always_comb begin
    acc = m3_ma + m3_mb + MW'(64'h8000_0000);
    if (m3_ctl.kind == ubli_pkg::KIND_FLAT) begin
      hi_sel = m3_f00;
    end else begin
      hi_sel = acc[SW+31:32];
    end
    z_full = {~hi_sel[SW-1], hi_sel[SW-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      span_invalid <= 1'b0;
    end else begin
      done         <= m3_ctl.valid && (m3_ctl.kind != ubli_pkg::KIND_WRITE);
      span_invalid <= m3_ctl.valid && (m3_ctl.kind == ubli_pkg::KIND_FLAT);
    end
    z_value <= 16'(z_full);
  end

endmodule
`default_nettype wire

/* rtl/uniform_bilinear_lut_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bilinear interpolation over a uniform grid table of signed samples.
// Items enter on start when busy is low. A write item (req_type 0) stores
// entry_value at entry_row/entry_col and gives no result. A lookup item
// (req_type 1) clamps x_pos/y_pos to the axis limits and returns z_value
// with span_invalid on a one-cycle done strobe.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no item is in flight (not enforced).
// Throughput is one item per clock. A lookup passes through the queue and
// the restoring divider, which resolves one quotient bit per pipeline
// stage for both axes, followed by the table read and two multiply stages
// of the blend before its result appears on done.
// Results cannot be held off; busy only rises if the queue between the
// input side and the divider fills. Reset restores the register defaults
// and empties the pipeline; table contents are undefined until written.
module uniform_bilinear_lut_interpolator #(
  parameter int MAX_COLS     = ubli_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = ubli_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_WIDTH = ubli_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [3:0]         entry_row,
  input  logic [3:0]         entry_col,
  input  logic signed [15:0] entry_value,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  output logic               done,
  output logic signed [15:0] z_value,
  output logic               span_invalid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int MAXN  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CW    = $clog2(MAXN);
  localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int NUMW  = 16 + CW;
  localparam int STEPS = CW + ubli_pkg::FRAC_BITS;
  localparam int TAGW  = SAMPLE_WIDTH + AW;
  localparam int QW    = $bits(ubli_pkg::item_kind_t) + 2 * NUMW + TAGW;

  logic signed [15:0] x_low;
  logic signed [15:0] x_high;
  logic [4:0]         grid_cols;
  logic signed [15:0] y_low;
  logic signed [15:0] y_high;
  logic [4:0]         grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low     <= ubli_pkg::RST_X_LOW;
      x_high    <= ubli_pkg::RST_X_HIGH;
      grid_cols <= ubli_pkg::RST_GRID_COLS;
      y_low     <= ubli_pkg::RST_Y_LOW;
      y_high    <= ubli_pkg::RST_Y_HIGH;
      grid_rows <= ubli_pkg::RST_GRID_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        ubli_pkg::CFG_X_LOW:     x_low     <= cfg_data;
        ubli_pkg::CFG_X_HIGH:    x_high    <= cfg_data;
        ubli_pkg::CFG_GRID_COLS: grid_cols <= cfg_data[4:0];
        ubli_pkg::CFG_Y_LOW:     y_low     <= cfg_data;
        ubli_pkg::CFG_Y_HIGH:    y_high    <= cfg_data;
        ubli_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic                     f_push;
  ubli_pkg::item_kind_t     f_kind;
  logic [NUMW-1:0]          f_num_x;
  logic [NUMW-1:0]          f_num_y;
  logic [SAMPLE_WIDTH-1:0]  f_sample;
  logic [AW-1:0]            f_waddr;

  ubli_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CW(CW),
    .AW(AW)
  ) u_front (
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .entry_row(entry_row),
    .entry_col(entry_col),
    .entry_value(entry_value),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .x_low(x_low),
    .x_high(x_high),
    .grid_cols(grid_cols),
    .y_low(y_low),
    .y_high(y_high),
    .grid_rows(grid_rows),
    .push(f_push),
    .kind(f_kind),
    .num_x(f_num_x),
    .num_y(f_num_y),
    .sample(f_sample),
    .waddr(f_waddr)
  );

  logic          q_valid;
  logic [QW-1:0] q_data;
  logic [QW-1:0] q_in;

  assign q_in = {f_kind, f_num_x, f_num_y, f_sample, f_waddr};

  ubli_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .push_data(q_in),
    .full(busy),
    .pop(q_valid),
    .out_valid(q_valid),
    .out_data(q_data)
  );

  ubli_pkg::ctl_t   d_in_ctl;
  logic [NUMW-1:0]  d_num_x;
  logic [NUMW-1:0]  d_num_y;
  logic [TAGW-1:0]  d_in_tag;
  logic [15:0]      span_x;
  logic [15:0]      span_y;

  always_comb begin
    d_in_ctl.valid = q_valid;
    d_in_ctl.kind  = ubli_pkg::item_kind_t'(q_data[QW-1 -: $bits(ubli_pkg::item_kind_t)]);
    d_num_x        = q_data[2*NUMW+TAGW-1 -: NUMW];
    d_num_y        = q_data[NUMW+TAGW-1 -: NUMW];
    d_in_tag       = q_data[TAGW-1:0];
    span_x         = x_high - x_low;
    span_y         = y_high - y_low;
  end

  ubli_pkg::ctl_t    d_out_ctl;
  logic [STEPS-1:0]  d_quo_x;
  logic [STEPS-1:0]  d_quo_y;
  logic [TAGW-1:0]   d_out_tag;

  ubli_div #(
    .CW(CW),
    .TAGW(TAGW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .in_ctl(d_in_ctl),
    .num_x(d_num_x),
    .num_y(d_num_y),
    .span_x(span_x),
    .span_y(span_y),
    .in_tag(d_in_tag),
    .out_ctl(d_out_ctl),
    .quo_x(d_quo_x),
    .quo_y(d_quo_y),
    .out_tag(d_out_tag)
  );

  ubli_back #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_ctl(d_out_ctl),
    .quo_x(d_quo_x),
    .quo_y(d_quo_y),
    .in_sample(d_out_tag[TAGW-1:AW]),
    .in_waddr(d_out_tag[AW-1:0]),
    .grid_cols(grid_cols),
    .grid_rows(grid_rows),
    .done(done),
    .z_value(z_value),
    .span_invalid(span_invalid)
  );

  a_queue_drains: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("Queue filled although the divider drains it every cycle.");

  a_flag_with_result: assert property (@(posedge clk) disable iff (rst)
    span_invalid |-> done)
    else $error("span_invalid raised without a result.");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("Result strobe right after reset.");

endmodule
`default_nettype wire

/* sim/lookup_checker.sv */
`timescale 1ns / 1ps
module lookup_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               req_type,
  input  logic [3:0]         entry_row,
  input  logic [3:0]         entry_col,
  input  logic signed [15:0] entry_value,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic               done,
  input  logic signed [15:0] z_value,
  input  logic               span_invalid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic [15:0] z;
    logic        flag;
  } lookup_result_t;

  logic signed [15:0] x_lo, x_hi, y_lo, y_hi;
  logic [4:0]         cols, rows;
  logic [15:0]        samples [16][16];
  lookup_result_t     pending_lookups [$];

  assign pending = pending_lookups.size();

  function automatic int intervals(input logic [4:0] n);
    if (n < 5'd2) return 1;
    if (n > 5'd16) return 15;
    return int'(n) - 1;
  endfunction

  task automatic locate(input logic signed [15:0] p, input logic signed [15:0] lo,
                        input logic signed [15:0] hi, input int nm1,
                        output int idx, output longint unsigned frac);
    longint span, pc, num, q, r;
    span = longint'(hi) - longint'(lo);
    pc = longint'(p);
    if (pc < longint'(lo)) pc = longint'(lo);
    if (pc > longint'(hi)) pc = longint'(hi);
    num = (pc - longint'(lo)) * nm1;
    q = num / span;
    r = num % span;
    if (q >= nm1) begin
      idx = nm1 - 1;
      frac = 64'd65536;
    end else begin
      idx = int'(q);
      frac = longint'((r * 65536) / span);
    end
  endtask

  function automatic longint unsigned lifted(input int r, input int c);
    return {48'd0, samples[r][c] ^ 16'h8000};
  endfunction

  task automatic predict_lookup(input logic signed [15:0] xp, input logic signed [15:0] yp,
                                output lookup_result_t res);
    int ix, iy;
    longint unsigned tx, ty, ra, rb, acc;
    if (x_hi <= x_lo || y_hi <= y_lo) begin
      res.z = samples[0][0];
      res.flag = 1'b1;
    end else begin
      locate(xp, x_lo, x_hi, intervals(cols), ix, tx);
      locate(yp, y_lo, y_hi, intervals(rows), iy, ty);
      ra = lifted(iy, ix) * (65536 - tx) + lifted(iy, ix + 1) * tx;
      rb = lifted(iy + 1, ix) * (65536 - tx) + lifted(iy + 1, ix + 1) * tx;
      acc = ra * (65536 - ty) + rb * ty + 64'h8000_0000;
      res.z = acc[47:32] ^ 16'h8000;
      res.flag = 1'b0;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    lookup_result_t res, want;
    if (rst) begin
      x_lo <= ubli_pkg::RST_X_LOW;
      x_hi <= ubli_pkg::RST_X_HIGH;
      cols <= ubli_pkg::RST_GRID_COLS;
      y_lo <= ubli_pkg::RST_Y_LOW;
      y_hi <= ubli_pkg::RST_Y_HIGH;
      rows <= ubli_pkg::RST_GRID_ROWS;
      pending_lookups.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ubli_pkg::CFG_X_LOW:     x_lo <= cfg_data;
          ubli_pkg::CFG_X_HIGH:    x_hi <= cfg_data;
          ubli_pkg::CFG_GRID_COLS: cols <= cfg_data[4:0];
          ubli_pkg::CFG_Y_LOW:     y_lo <= cfg_data;
          ubli_pkg::CFG_Y_HIGH:    y_hi <= cfg_data;
          ubli_pkg::CFG_GRID_ROWS: rows <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (done) begin
        if (pending_lookups.size() == 0) begin
          errors++;
          $display("%0t: unexpected result z=%0d flag=%0b", $time, z_value, span_invalid);
        end else begin
          want = pending_lookups.pop_front();
          if (z_value !== want.z) begin
            errors++;
            $display("%0t: z_value expected %0d actual %0d", $time,
                     $signed(want.z), z_value);
          end
          if (span_invalid !== want.flag) begin
            errors++;
            $display("%0t: span_invalid expected %0b actual %0b", $time,
                     want.flag, span_invalid);
          end
        end
      end
      if (start && !busy) begin
        if (req_type == ubli_pkg::REQ_WRITE) begin
          samples[entry_row][entry_col] = entry_value;
        end else begin
          predict_lookup(x_pos, y_pos, res);
          pending_lookups.push_back(res);
        end
      end
    end
  end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN = 40;

  logic               clk, rst, start, busy, req_type, done, span_invalid, cfg_we;
  logic [3:0]         entry_row, entry_col;
  logic signed [15:0] entry_value, x_pos, y_pos, z_value;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 errors, pending, cycles;
  bit                 no_gaps;

  uniform_bilinear_lut_interpolator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .entry_row(entry_row), .entry_col(entry_col), .entry_value(entry_value),
    .x_pos(x_pos), .y_pos(y_pos), .done(done), .z_value(z_value),
    .span_invalid(span_invalid), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lookup_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .entry_row(entry_row), .entry_col(entry_col), .entry_value(entry_value),
    .x_pos(x_pos), .y_pos(y_pos), .done(done), .z_value(z_value),
    .span_invalid(span_invalid), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic issue(input logic kind, input logic [3:0] r, input logic [3:0] c,
                       input logic [15:0] v, input logic [15:0] xp, input logic [15:0] yp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    entry_row <= r;
    entry_col <= c;
    entry_value <= v;
    x_pos <= xp;
    y_pos <= yp;
    do @(posedge clk); while (busy);
  endtask

  task automatic store(input logic [3:0] r, input logic [3:0] c, input logic [15:0] v);
    issue(ubli_pkg::REQ_WRITE, r, c, v, 16'($urandom), 16'($urandom));
  endtask

  task automatic probe(input logic [15:0] xp, input logic [15:0] yp);
    issue(ubli_pkg::REQ_LOOKUP, 4'($urandom), 4'($urandom), 16'($urandom), xp, yp);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input logic [15:0] xl, input logic [15:0] xh, input logic [4:0] nc,
                          input logic [15:0] yl, input logic [15:0] yh, input logic [4:0] nr);
    set_reg(ubli_pkg::CFG_X_LOW, xl);
    set_reg(ubli_pkg::CFG_X_HIGH, xh);
    set_reg(ubli_pkg::CFG_GRID_COLS, {11'($urandom_range(2047)), nc});
    set_reg(ubli_pkg::CFG_Y_LOW, yl);
    set_reg(ubli_pkg::CFG_Y_HIGH, yh);
    set_reg(ubli_pkg::CFG_GRID_ROWS, {11'($urandom_range(2047)), nr});
  endtask

  task automatic random_coord(input logic [15:0] lo, input logic [15:0] hi,
                              output logic [15:0] p);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) p = lo;
    else if (pick == 1) p = hi;
    else if (pick < 4) p = 16'($urandom);
    else if ($signed(hi) > $signed(lo))
      p = 16'(int'($signed(lo)) + $urandom_range(int'($signed(hi)) - int'($signed(lo))));
    else p = 16'($urandom);
  endtask

  initial begin
    logic [15:0] xl, xh, yl, yh, xp, yp;
    logic [4:0]  nc, nr;
    rst = 1'b1;
    start = 1'b0;
    req_type = ubli_pkg::REQ_WRITE;
    entry_row = '0;
    entry_col = '0;
    entry_value = '0;
    x_pos = '0;
    y_pos = '0;
    cfg_we = 1'b0;
    cfg_index = ubli_pkg::CFG_X_LOW;
    cfg_data = '0;
    no_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The whole table is filled first so that no lookup reads an unwritten entry.
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) store(4'(r), 4'(c), 16'($urandom));
    no_gaps = 1'b0;
    store(0, 0, 16'h8000);
    store(0, 1, 16'h7FFF);
    store(1, 0, 16'h7FFF);
    store(1, 1, 16'h8000);
    store(15, 15, 16'h7FFF);
    probe(16'h0000, 16'h0000);
    probe(16'h7FFF, 16'h7FFF);
    probe(16'h8000, 16'h8000);
    probe(16'h0800, 16'h0001);
    probe(16'h0400, 16'h0C00);
    probe(16'h7FFE, 16'h0000);
    settle();
    set_grid(16'h8000, 16'h7FFF, 5'd2, 16'h8000, 16'h7FFF, 5'd2);
    probe(16'h8000, 16'h7FFF);
    probe(16'h0000, 16'h0000);
    probe(16'hFFFF, 16'h0001);
    settle();
    set_grid(16'h0010, 16'h0010, 5'd0, 16'h0000, 16'h0100, 5'd31);
    probe(16'h0010, 16'h0050);
    probe(16'h8000, 16'h7FFF);
    settle();
    set_grid(16'h0000, 16'h0100, 5'd1, 16'h0200, 16'h0100, 5'd16);
    probe(16'h0050, 16'h0150);
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin xl = 16'h8000; xh = 16'h7FFF; nc = 16; yl = 16'h8000; yh = 16'h7FFF; nr = 16; end
        1: begin xl = 16'h0000; xh = 16'h0001; nc = 16; yl = 16'h0005; yh = 16'h0007; nr = 3; end
        2: begin xl = 16'h7FFE; xh = 16'h7FFF; nc = 0; yl = 16'h8000; yh = 16'h8001; nr = 31; end
        3: begin xl = 16'h0020; xh = 16'h0020; nc = 5; yl = 16'h0000; yh = 16'h0010; nr = 5; end
        default: begin
          xl = 16'($urandom);
          xh = 16'($urandom);
          yl = 16'($urandom);
          yh = 16'($urandom);
          if ($signed(xh) < $signed(xl)) begin xp = xl; xl = xh; xh = xp; end
          if ($signed(yh) < $signed(yl)) begin yp = yl; yl = yh; yh = yp; end
          nc = 5'($urandom);
          nr = 5'($urandom);
        end
      endcase
      set_grid(xl, xh, nc, yl, yh, nr);
      no_gaps = (phase % 3 == 0);
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(9) < 3) begin
          store(4'($urandom), 4'($urandom), 16'($urandom));
        end else begin
          random_coord(xl, xh, xp);
          random_coord(yl, yh, yp);
          probe(xp, yp);
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/ubli_pkg.sv
rtl/ubli_front.sv
rtl/ubli_queue.sv
rtl/ubli_div.sv
rtl/ubli_back.sv
rtl/uniform_bilinear_lut_interpolator.sv
sim/lookup_checker.sv
sim/tb_top.sv
